// ===== rtl/core/dmks_pkg.sv =====
// Package for the display multiplexer and key scanner: item types and codes.
`default_nettype none

package dmks_pkg;

  // Operation codes carried in an input item
  typedef enum logic [0:0] {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } dmks_op_e;

  // Configuration port
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] CFG_REFRESH_PERIOD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RELEASE_TICKS  = 2'd1;

  // Reset values
  localparam logic [7:0] REFRESH_PERIOD_RST = 8'd4;
  localparam logic [1:0] RELEASE_TICKS_RST  = 2'd2;

  // Released patterns of the key groups
  localparam logic [7:0] KEYS_IDLE     = 8'hff;
  localparam logic [2:0] FUN_KEYS_IDLE = 3'h7;

  // Select port: all lines high, digit n pulls bit 4+n low
  localparam logic [7:0] SEL_ALL_OFF = 8'hff;
  localparam logic [7:0] SEL_DIGIT0  = 8'h10;

  typedef struct packed {
    dmks_op_e   opcode;
    logic [1:0] digit_index;
    logic [7:0] digit_segments;
    logic [7:0] key_lines;
    logic [2:0] fun_key_lines;
  } dmks_in_t;

  typedef struct packed {
    logic [7:0] digit_select;
    logic [7:0] segment_out;
    logic       scan_done;
    logic       key_event;
    logic       fun_key_event;
    logic [7:0] keys_pressed;
    logic [2:0] fun_keys_pressed;
  } dmks_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/display_mux_key_scanner.sv =====
// Top level: multiplexed digit display driver with debounced key scan.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) carries ticks and
//   display writes. A write item updates one digit of the display store and
//   gives no result. A tick item drives the next digit and, every
//   refresh_period+1 ticks, scans the key lines; it gives one result item.
//   Output channel (out_valid_o / out_stall_i / out_item_o) carries results.
//   Configuration port (cfg_valid_i / cfg_ready_o) writes refresh_period
//   (index 0) and release_ticks (index 1); it is always ready, and a new
//   value takes effect at the next countdown reload or wait rearm.
//   Throughput: one item per cycle while in_stall_o is low, set by the
//   single state update per item.
//   When the receiver stalls, the result is held in the output register and
//   one more item is taken into a skid register; only then is in_stall_o
//   raised, until the output drains.
//   Reset: display store cleared, digit pointer 0, countdown 4, release
//   wait 2, latched keys 0, registers back to 4 and 2, no result pending.
`default_nettype none

module display_mux_key_scanner
  import dmks_pkg::*;
#(
  parameter int unsigned NUM_DIGITS = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire dmks_in_t            in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output dmks_out_t                out_item_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam logic [IdxW-1:0] LastDigit = IdxW'(NUM_DIGITS - 1);
  localparam logic [2:0] NumDigitsW = 3'(NUM_DIGITS);

  // Configuration registers
  logic [7:0] refresh_period_q;
  logic [1:0] release_ticks_q;

  // Block state
  logic [IdxW-1:0] digit_pointer_q, digit_pointer_d;
  logic [7:0]      display_store_q [NUM_DIGITS];
  logic [7:0]      refresh_countdown_q, refresh_countdown_d;
  logic [1:0]      release_wait_q, release_wait_d;
  logic [7:0]      latched_keys_q, latched_keys_d;
  logic [2:0]      latched_fun_keys_q, latched_fun_keys_d;

  // Output register and skid stage
  logic      out_valid_q, skid_valid_q;
  dmks_out_t out_q, skid_q;

  logic      in_accept, out_take, is_tick, is_write, write_hit;
  logic      keys_down, fun_down;
  dmks_out_t result;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_accept   = in_valid_i && !skid_valid_q;
  assign out_take    = out_valid_q && !out_stall_i;
  assign is_tick     = (in_item_i.opcode == OP_TICK);
  assign is_write    = (in_item_i.opcode == OP_WRITE);
  assign write_hit   = ({1'b0, in_item_i.digit_index} < NumDigitsW);
  assign keys_down   = (in_item_i.key_lines != KEYS_IDLE);
  assign fun_down    = (in_item_i.fun_key_lines != FUN_KEYS_IDLE);

  // Tick processing: digit drive and key scan
  always_comb begin
    logic scan, kev, fev;
    digit_pointer_d     = (digit_pointer_q == LastDigit) ? '0 : digit_pointer_q + 1'b1;
    refresh_countdown_d = refresh_countdown_q;
    release_wait_d      = release_wait_q;
    latched_keys_d      = latched_keys_q;
    latched_fun_keys_d  = latched_fun_keys_q;
    scan = 1'b0;
    kev  = 1'b0;
    fev  = 1'b0;
    if (refresh_countdown_q != '0) begin
      refresh_countdown_d = refresh_countdown_q - 1'b1;
    end else begin
      scan = 1'b1;
      refresh_countdown_d = refresh_period_q;
      priority if (release_wait_q == '0) begin
        if (keys_down) begin
          latched_keys_d = in_item_i.key_lines ^ KEYS_IDLE;
          release_wait_d = release_ticks_q;
          kev = 1'b1;
        end
        if (fun_down) begin
          latched_fun_keys_d = in_item_i.fun_key_lines ^ FUN_KEYS_IDLE;
          release_wait_d = release_ticks_q;
          fev = 1'b1;
        end
      end else if (!keys_down && !fun_down) begin
        release_wait_d = release_wait_q - 1'b1;
      end else begin
        release_wait_d = release_ticks_q;
      end
    end
    result.digit_select     = SEL_ALL_OFF & ~(SEL_DIGIT0 << digit_pointer_q);
    result.segment_out      = display_store_q[digit_pointer_q];
    result.scan_done        = scan;
    result.key_event        = kev;
    result.fun_key_event    = fev;
    result.keys_pressed     = latched_keys_d;
    result.fun_keys_pressed = latched_fun_keys_d;
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refresh_period_q <= REFRESH_PERIOD_RST;
      release_ticks_q  <= RELEASE_TICKS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_REFRESH_PERIOD) begin
        refresh_period_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_RELEASE_TICKS) begin
        release_ticks_q <= cfg_data_i[1:0];
      end
    end
  end

  // Block state update on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_pointer_q     <= '0;
      refresh_countdown_q <= REFRESH_PERIOD_RST;
      release_wait_q      <= RELEASE_TICKS_RST;
      latched_keys_q      <= '0;
      latched_fun_keys_q  <= '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        display_store_q[i] <= '0;
      end
    end else if (in_accept) begin
      if (is_write) begin
        if (write_hit) begin
          display_store_q[in_item_i.digit_index[IdxW-1:0]] <= in_item_i.digit_segments;
        end
      end else begin
        digit_pointer_q     <= digit_pointer_d;
        refresh_countdown_q <= refresh_countdown_d;
        release_wait_q      <= release_wait_d;
        latched_keys_q      <= latched_keys_d;
        latched_fun_keys_q  <= latched_fun_keys_d;
      end
    end
  end

  // Output register with one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_take) begin
          out_q        <= skid_q;
          skid_valid_q <= 1'b0;
        end
      end else if (in_accept && is_tick) begin
        if (!out_valid_q || out_take) begin
          out_q       <= result;
          out_valid_q <= 1'b1;
        end else begin
          skid_q       <= result;
          skid_valid_q <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef NO_ASSERTIONS
  // The skid entry is only ever filled behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid without a result in the output register");

  // A drained skid entry is the next result shown
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_take) |=> (out_valid_q && out_q == $past(skid_q)))
    else $error("skid entry lost on output drain");

  // Key events only come from a scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.scan_done) |-> (!out_q.key_event && !out_q.fun_key_event))
    else $error("key event flagged on a tick without a scan");
`endif

endmodule

`default_nettype wire

// ===== bench/display_mux_key_scanner_test.sv =====
// Self-checking bench for the display multiplexer and key scanner top level.
`default_nettype none

module display_mux_key_scanner_test;
  import dmks_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_DIGITS   = 4;
  localparam int          CLK_PERIOD   = 8;
  localparam int          RESET_CYCLES = 6;
  localparam int          IDLE_PAUSE   = 4;
  localparam int          HOLD_CYCLES  = 120;
  localparam int          CYCLE_LIMIT  = 400000;

  // Register indexes with no register behind them
  localparam logic [CfgIdxW-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_3 = 2'd3;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  dmks_in_t            in_item_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  dmks_out_t           out_item_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  display_mux_key_scanner #(
    .NUM_DIGITS (NUM_DIGITS)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Shadow of the block: registers and state
  logic [7:0] period_cfg  = REFRESH_PERIOD_RST;
  logic [1:0] release_cfg = RELEASE_TICKS_RST;
  logic [1:0] digit_ptr   = '0;
  logic [7:0] digit_segs [NUM_DIGITS] = '{default: 8'h00};
  logic [7:0] countdown   = REFRESH_PERIOD_RST;
  logic [1:0] release_cnt = RELEASE_TICKS_RST;
  logic [7:0] held_keys   = '0;
  logic [2:0] held_fun    = '0;

  dmks_in_t  items_pending [$];
  dmks_out_t frames_due [$];
  int        errors   = 0;
  int        cycles   = 0;
  bit        calm     = 1'b0;
  bit        hold_go  = 1'b0;

  // Next display frame for one item; returns 0 for a display write
  function automatic bit next_frame(input dmks_in_t it, output dmks_out_t fr);
    fr = '0;
    if (it.opcode == OP_WRITE) begin
      if (it.digit_index < NUM_DIGITS) digit_segs[it.digit_index] = it.digit_segments;
      return 1'b0;
    end
    fr.segment_out  = digit_segs[digit_ptr];
    fr.digit_select = SEL_ALL_OFF ^ (SEL_DIGIT0 << digit_ptr);
    digit_ptr = (digit_ptr == NUM_DIGITS - 1) ? 2'd0 : digit_ptr + 2'd1;
    if (countdown != 8'd0) begin
      countdown = countdown - 8'd1;
    end else begin
      fr.scan_done = 1'b1;
      countdown = period_cfg;
      if (release_cnt == 2'd0) begin
        if (it.key_lines != KEYS_IDLE) begin
          held_keys    = it.key_lines ^ KEYS_IDLE;
          release_cnt  = release_cfg;
          fr.key_event = 1'b1;
        end
        if (it.fun_key_lines != FUN_KEYS_IDLE) begin
          held_fun         = it.fun_key_lines ^ FUN_KEYS_IDLE;
          release_cnt      = release_cfg;
          fr.fun_key_event = 1'b1;
        end
      end else if (it.key_lines == KEYS_IDLE && it.fun_key_lines == FUN_KEYS_IDLE) begin
        release_cnt = release_cnt - 2'd1;
      end else begin
        release_cnt = release_cfg;
      end
    end
    fr.keys_pressed     = held_keys;
    fr.fun_keys_pressed = held_fun;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Driver: offers pending items, random gaps, holds a stalled item steady
  int        gap_left = 0;
  dmks_out_t new_frame;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (next_frame(in_item_i, new_frame)) frames_due.push_back(new_frame);
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(1, 18) - 1;
          in_valid_i <= 1'b0;
        end else if (items_pending.size() > 0) begin
          in_item_i  <= items_pending.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted frame, drives the output stall
  int        stall_left = 0;
  int        hold_left  = 0;
  bit        hold_done  = 1'b0;
  dmks_out_t want;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (frames_due.size() == 0) begin
          errors++;
          $display("%0t ns: frame with none expected, actual %0h", $time, out_item_o);
        end else begin
          want = frames_due.pop_front();
          check_field("digit_select", want.digit_select, out_item_o.digit_select);
          check_field("segment_out", want.segment_out, out_item_o.segment_out);
          check_field("scan_done", 8'(want.scan_done), 8'(out_item_o.scan_done));
          check_field("key_event", 8'(want.key_event), 8'(out_item_o.key_event));
          check_field("fun_key_event", 8'(want.fun_key_event),
                      8'(out_item_o.fun_key_event));
          check_field("keys_pressed", want.keys_pressed, out_item_o.keys_pressed);
          check_field("fun_keys_pressed", 8'(want.fun_keys_pressed),
                      8'(out_item_o.fun_keys_pressed));
        end
      end
      // long hold-off once, so the block backs up into its input
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("display_mux_key_scanner_test: errors");
      $finish;
    end
  end

  task automatic push_tick(input logic [7:0] keys, input logic [2:0] fun);
    dmks_in_t it;
    it                = '0;
    it.opcode         = OP_TICK;
    it.digit_index    = 2'($urandom_range(0, 3));
    it.digit_segments = 8'($urandom);
    it.key_lines      = keys;
    it.fun_key_lines  = fun;
    items_pending.push_back(it);
  endtask

  task automatic push_write(input logic [1:0] idx, input logic [7:0] seg);
    dmks_in_t it;
    it                = '0;
    it.opcode         = OP_WRITE;
    it.digit_index    = idx;
    it.digit_segments = seg;
    it.key_lines      = 8'($urandom);
    it.fun_key_lines  = 3'($urandom);
    items_pending.push_back(it);
  endtask

  // Alternating press and release runs, with noise items mixed in
  task automatic queue_session(input int n, input int write_pct);
    int         run_left = 0;
    int         run_max;
    bit         pressing = 1'b0;
    logic [7:0] keys     = KEYS_IDLE;
    logic [2:0] fun      = FUN_KEYS_IDLE;
    run_max = 4 * (int'(period_cfg) + 1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < write_pct) begin
        push_write(2'($urandom_range(0, 3)), 8'($urandom));
      end else begin
        if (run_left == 0) begin
          pressing = !pressing;
          run_left = $urandom_range(1, run_max);
          if (!pressing) begin
            keys = KEYS_IDLE;
            fun  = FUN_KEYS_IDLE;
          end else begin
            case ($urandom_range(0, 2))
              0: begin
                keys = KEYS_IDLE ^ (8'h01 << $urandom_range(0, 7));
                fun  = FUN_KEYS_IDLE;
              end
              1: begin
                keys = KEYS_IDLE;
                fun  = FUN_KEYS_IDLE ^ (3'h1 << $urandom_range(0, 2));
              end
              default: begin
                keys = 8'($urandom);
                fun  = 3'($urandom);
              end
            endcase
          end
        end
        run_left--;
        if ($urandom_range(0, 11) == 0) push_tick(8'($urandom), 3'($urandom));
        else push_tick(keys, fun);
      end
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_REFRESH_PERIOD: period_cfg  = data;
      CFG_RELEASE_TICKS:  release_cfg = data[1:0];
      default: ;
    endcase
  endtask

  // Wait for all items and frames to clear, then let the pipeline settle
  task automatic wait_idle();
    do @(negedge clk_i);
    while (items_pending.size() != 0 || in_valid_i || frames_due.size() != 0);
    repeat (IDLE_PAUSE) @(negedge clk_i);
  endtask

  logic [7:0] periods   [5] = '{8'd1, 8'd3, 8'd2, 8'd7, 8'd0};
  logic [7:0] releases  [5] = '{8'h01, 8'hff, 8'h02, 8'h00, 8'h5d};

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: digit store extremes, wait run-out, full press, rewrite
    push_write(2'd0, 8'h00);
    push_write(2'd1, 8'hff);
    push_write(2'd2, 8'ha5);
    push_write(2'd3, 8'h5a);
    repeat (10) push_tick(KEYS_IDLE, FUN_KEYS_IDLE);
    repeat (5) push_tick(8'h00, 3'h0);
    push_write(2'd0, 8'h81);
    repeat (4) push_tick(8'h7f, FUN_KEYS_IDLE);
    wait_idle();

    // Longest refresh period, slowest release
    write_reg(CFG_REFRESH_PERIOD, 8'hff);
    write_reg(CFG_RELEASE_TICKS, 8'h03);
    queue_session(260, 5);
    wait_idle();

    // Scan every tick, zero release wait, spare indexes written
    write_reg(CFG_REFRESH_PERIOD, 8'h00);
    write_reg(CFG_RELEASE_TICKS, 8'hfc);
    write_reg(CFG_SPARE_2, 8'($urandom));
    write_reg(CFG_SPARE_3, 8'($urandom));
    queue_session(120, 10);
    @(posedge clk_i);
    hold_go <= 1'b1;
    wait_idle();

    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_REFRESH_PERIOD, periods[p]);
      write_reg(CFG_RELEASE_TICKS, releases[p]);
      if (p == 4) begin
        @(posedge clk_i);
        calm <= 1'b1;
      end
      queue_session(70, 10);
      wait_idle();
    end

    repeat (8) @(negedge clk_i);
    if (frames_due.size() != 0) begin
      errors++;
      $display("%0t ns: %0d frames never arrived", $time, frames_due.size());
    end
    if (errors == 0) begin
      $display("display_mux_key_scanner_test: clean");
    end else begin
      $display("display_mux_key_scanner_test: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
